// ===== src/csw_pkg.sv =====
// ---------------------------------------------------------------------------
// csw_pkg: shared types and constants of the count sliding window expirer
// Window geometry, result codes and the stage record passed from the
// window control to the result emitter.
// ---------------------------------------------------------------------------
package csw_pkg;

    localparam int WINDOW_DEPTH = 1024;
    localparam int HANDLE_BITS  = 32;

    localparam int STAMP_W  = 32;
    localparam int HANDLE_W = 32;
    localparam int WSIZE_W  = 11;
    localparam int PTR_W    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int FILL_W   = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W    = FILL_W + 1;
    localparam int CMP_W    = (FILL_W > WSIZE_W) ? FILL_W : WSIZE_W;

    // Configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;
    localparam int CFG_WINDOW_SIZE = 0;

    typedef enum logic [1:0] {
        KIND_INSERT    = 2'd0,
        KIND_DELETE    = 2'd1,
        KIND_HEARTBEAT = 2'd2
    } kind_t;

    typedef struct packed {
        logic                   has_result;
        logic                   is_heartbeat;
        logic                   expire;
        logic [HANDLE_BITS-1:0] handle;
        logic [STAMP_W-1:0]     stamp;
    } item_t;

    // Fit a port handle to the stored handle width
    function automatic logic [HANDLE_BITS-1:0] to_store(input logic [HANDLE_W-1:0] h);
        logic [63:0] w;
        w = 64'(h);
        return w[HANDLE_BITS-1:0];
    endfunction

    // Fit a stored handle to the port handle width
    function automatic logic [HANDLE_W-1:0] to_port(input logic [HANDLE_BITS-1:0] h);
        logic [63:0] w;
        w = 64'(h);
        return w[HANDLE_W-1:0];
    endfunction

endpackage

// ===== src/csw_in_if.sv =====
// ---------------------------------------------------------------------------
// csw_in_if: input element channel
// Valid/ready channel carrying one stream element per transaction.
// ---------------------------------------------------------------------------
interface csw_in_if;
    logic        valid;
    logic        ready;
    logic        is_heartbeat;
    logic [31:0] stamp;
    logic [31:0] tuple_handle;

    modport source (output valid, output is_heartbeat, output stamp, output tuple_handle,
                    input ready);
    modport sink   (input valid, input is_heartbeat, input stamp, input tuple_handle,
                    output ready);
endinterface

// ===== src/csw_out_if.sv =====
// ---------------------------------------------------------------------------
// csw_out_if: result channel
// Valid/ready channel carrying one result per transaction.
// ---------------------------------------------------------------------------
interface csw_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] out_handle;
    logic [31:0] out_stamp;
    logic        last;

    modport source (output valid, output kind, output out_handle, output out_stamp,
                    output last, input ready);
    modport sink   (input valid, input kind, input out_handle, input out_stamp,
                    input last, output ready);
endinterface

// ===== src/csw_window_ram.sv =====
// ---------------------------------------------------------------------------
// csw_window_ram: simple dual-port RAM
// One write port and one registered read port; a read of the address being
// written returns the old contents.
// ---------------------------------------------------------------------------
module csw_window_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32,
    parameter int AW    = 10
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/csw_ctrl.sv =====
// ---------------------------------------------------------------------------
// csw_ctrl: window bookkeeping
// Holds the ring pointers and stamps, decides each element's results,
// issues the window RAM accesses and holds the element until the emitter takes it.
// ---------------------------------------------------------------------------
module csw_ctrl
    import csw_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [WSIZE_W-1:0]     window_size,
    csw_in_if.sink                 in_ch,
    output logic                   a_valid,
    output item_t                  a_item,
    input  logic                   a_take,
    output logic                   ram_we,
    output logic [PTR_W-1:0]       ram_waddr,
    output logic [HANDLE_BITS-1:0] ram_wdata,
    output logic                   ram_re,
    output logic [PTR_W-1:0]       ram_raddr
);

    logic [PTR_W-1:0]   oldest_reg, oldest_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [STAMP_W-1:0] last_out_reg, last_out_next;
    logic               a_valid_reg, a_valid_next;
    item_t              a_item_reg, a_item_next;

    logic               accept;
    logic [CMP_W-1:0]   size_ext;
    logic [CMP_W-1:0]   eff_size;
    logic               expire;
    logic               hb_due;
    logic [SUM_W-1:0]   wsum;
    logic [PTR_W-1:0]   wpos;
    logic [PTR_W-1:0]   oldest_inc;

    assign in_ch.ready = !a_valid_reg || a_take;
    assign accept      = in_ch.valid && in_ch.ready;

    // Clamp the window size to 1..WINDOW_DEPTH
    always_comb
    begin
        size_ext = CMP_W'(window_size);
        if (size_ext == '0)
        begin
            eff_size = CMP_W'(1);
        end
        else if (size_ext > CMP_W'(WINDOW_DEPTH))
        begin
            eff_size = CMP_W'(WINDOW_DEPTH);
        end
        else
        begin
            eff_size = size_ext;
        end
    end

    assign expire = CMP_W'(fill_reg) >= eff_size;
    assign hb_due = last_out_reg < in_ch.stamp;

    // Tail slot: oldest + fill wraps at most once
    assign wsum = SUM_W'(oldest_reg) + SUM_W'(fill_reg);
    assign wpos = (wsum >= SUM_W'(WINDOW_DEPTH)) ? PTR_W'(wsum - SUM_W'(WINDOW_DEPTH))
                                                 : PTR_W'(wsum);
    assign oldest_inc = (oldest_reg == PTR_W'(WINDOW_DEPTH - 1)) ? '0
                                                                 : oldest_reg + PTR_W'(1);

    assign ram_we    = accept && !in_ch.is_heartbeat;
    assign ram_waddr = wpos;
    assign ram_wdata = to_store(in_ch.tuple_handle);
    assign ram_re    = accept && !in_ch.is_heartbeat && expire;
    assign ram_raddr = oldest_reg;

    always_comb
    begin
        oldest_next   = oldest_reg;
        fill_next     = fill_reg;
        last_out_next = last_out_reg;
        a_valid_next  = a_valid_reg;
        a_item_next   = a_item_reg;
        if (a_take)
        begin
            a_valid_next = 1'b0;
        end
        if (accept)
        begin
            a_valid_next             = 1'b1;
            a_item_next.is_heartbeat = in_ch.is_heartbeat;
            a_item_next.handle       = to_store(in_ch.tuple_handle);
            a_item_next.stamp        = in_ch.stamp;
            if (in_ch.is_heartbeat)
            begin
                a_item_next.has_result = hb_due;
                a_item_next.expire     = 1'b0;
                if (hb_due)
                begin
                    last_out_next = in_ch.stamp;
                end
            end
            else
            begin
                a_item_next.has_result = 1'b1;
                a_item_next.expire     = expire;
                last_out_next          = in_ch.stamp;
                if (expire)
                begin
                    oldest_next = oldest_inc;
                end
                else
                begin
                    fill_next = fill_reg + FILL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oldest_reg   <= '0;
            fill_reg     <= '0;
            last_out_reg <= '0;
            a_valid_reg  <= 1'b0;
        end
        else
        begin
            oldest_reg   <= oldest_next;
            fill_reg     <= fill_next;
            last_out_reg <= last_out_next;
            a_valid_reg  <= a_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_item_reg <= a_item_next;
    end

    assign a_valid = a_valid_reg;
    assign a_item  = a_item_reg;

endmodule

// ===== src/csw_emit.sv =====
// ---------------------------------------------------------------------------
// csw_emit: result emitter
// Output register that presents an insert or heartbeat, then the delete of
// the expired tuple when the element caused one.
// ---------------------------------------------------------------------------
module csw_emit
    import csw_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   a_valid,
    input  item_t                  a_item,
    output logic                   a_take,
    input  logic [HANDLE_BITS-1:0] rd_handle,
    csw_out_if.source              out_ch
);

    logic                e_valid_reg, e_valid_next;
    kind_t               e_kind_reg, e_kind_next;
    logic [HANDLE_W-1:0] e_handle_reg, e_handle_next;
    logic [STAMP_W-1:0]  e_stamp_reg, e_stamp_next;
    logic                e_last_reg, e_last_next;
    logic [HANDLE_W-1:0] e_del_reg, e_del_next;

    logic out_fire;
    logic free;
    logic load;

    assign out_fire = e_valid_reg && out_ch.ready;
    assign free     = !e_valid_reg || (out_fire && e_last_reg);
    assign load     = a_valid && a_item.has_result && free;
    // An element with no result drops at once
    assign a_take   = a_valid && (!a_item.has_result || free);

    always_comb
    begin
        e_valid_next  = e_valid_reg;
        e_kind_next   = e_kind_reg;
        e_handle_next = e_handle_reg;
        e_stamp_next  = e_stamp_reg;
        e_last_next   = e_last_reg;
        e_del_next    = e_del_reg;
        if (out_fire && !e_last_reg)
        begin
            e_kind_next   = KIND_DELETE;
            e_handle_next = e_del_reg;
            e_last_next   = 1'b1;
        end
        else if (load)
        begin
            e_valid_next  = 1'b1;
            e_kind_next   = a_item.is_heartbeat ? KIND_HEARTBEAT : KIND_INSERT;
            e_handle_next = a_item.is_heartbeat ? '0 : to_port(a_item.handle);
            e_stamp_next  = a_item.stamp;
            e_last_next   = !a_item.expire;
            e_del_next    = to_port(rd_handle);
        end
        else if (out_fire)
        begin
            e_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
        end
        else
        begin
            e_valid_reg <= e_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e_kind_reg   <= e_kind_next;
        e_handle_reg <= e_handle_next;
        e_stamp_reg  <= e_stamp_next;
        e_last_reg   <= e_last_next;
        e_del_reg    <= e_del_next;
    end

    assign out_ch.valid      = e_valid_reg;
    assign out_ch.kind       = e_kind_reg;
    assign out_ch.out_handle = e_handle_reg;
    assign out_ch.out_stamp  = e_stamp_reg;
    assign out_ch.last       = e_last_reg;

endmodule

// ===== src/count_sliding_window_expirer_unit.sv =====
// ---------------------------------------------------------------------------
// count_sliding_window_expirer_unit: count-based sliding window expirer
// Forwards stream tuples as inserts, expires the oldest tuple once the window
// is full, and turns heartbeats that advance time into heartbeat results.
// ---------------------------------------------------------------------------
// Every data tuple leaves as an insert transaction; once the window already
// holds window_size tuples it is followed by a delete transaction carrying the
// oldest stored handle and the new tuple's stamp (last marks the final result
// of an element). A heartbeat yields one heartbeat transaction only when its
// stamp is later than the last emitted stamp. The window lives in a
// WINDOW_DEPTH-entry RAM with a registered read port: the oldest entry is read
// and the new handle written in the cycle the element is accepted. A new
// element is accepted every cycle while each one yields at most one result
// and the output is not stalled; an element that yields an insert and a
// delete holds the single result register for both, so the next element
// waits until that delete is taken. Results pass the element register, then
// the result register. The user must write window_size (register 0) through
// the APB port only while the block is idle; the block does not enforce it.
// Zero acts as 1 and values above WINDOW_DEPTH act as WINDOW_DEPTH.
module count_sliding_window_expirer_unit
    import csw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    csw_in_if.sink                in_ch,
    csw_out_if.source             out_ch
);

    logic [WSIZE_W-1:0]     window_size_reg, window_size_next;
    logic                   reg_hit;
    logic                   cfg_write;

    logic                   a_valid;
    item_t                  a_item;
    logic                   a_take;
    logic                   ram_we;
    logic [PTR_W-1:0]       ram_waddr;
    logic [HANDLE_BITS-1:0] ram_wdata;
    logic                   ram_re;
    logic [PTR_W-1:0]       ram_raddr;
    logic [HANDLE_BITS-1:0] ram_rdata;

    // Configuration port: zero wait states, decode on the word index
    assign pready    = 1'b1;
    assign reg_hit   = paddr[APB_ADDR_W-1:2] == REG_IDX_W'(CFG_WINDOW_SIZE);
    assign cfg_write = psel && penable && pwrite && reg_hit;
    assign prdata    = reg_hit ? APB_DATA_W'(window_size_reg) : '0;

    always_comb
    begin
        window_size_next = window_size_reg;
        if (cfg_write)
        begin
            window_size_next = pwdata[WSIZE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= WSIZE_W'(1);
        end
        else
        begin
            window_size_reg <= window_size_next;
        end
    end

    // Decide each element, advance the ring, drive the window RAM
    csw_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .window_size (window_size_reg),
        .in_ch       (in_ch),
        .a_valid     (a_valid),
        .a_item      (a_item),
        .a_take      (a_take),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr)
    );

    // Window store; read of the slot being overwritten returns the old handle
    csw_window_ram #(
        .DEPTH (WINDOW_DEPTH),
        .WIDTH (HANDLE_BITS),
        .AW    (PTR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Present results one transaction at a time
    csw_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .a_valid   (a_valid),
        .a_item    (a_item),
        .a_take    (a_take),
        .rd_handle (ram_rdata),
        .out_ch    (out_ch)
    );

    // An insert that is not last is always followed by its delete
    a_insert_then_delete: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.ready && out_ch.kind == KIND_INSERT && !out_ch.last)
        |=> (out_ch.valid && out_ch.kind == KIND_DELETE && out_ch.last))
        else $error("insert without its delete");

    // Heartbeats are single results with no handle
    a_heartbeat_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.kind == KIND_HEARTBEAT)
        |-> (out_ch.last && out_ch.out_handle == '0))
        else $error("malformed heartbeat result");

    // Input stalls only behind a pending result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> out_ch.valid)
        else $error("input stalled with no result pending");

    // Delete carries the stamp of the insert that caused it
    a_delete_stamp: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.ready && out_ch.kind == KIND_INSERT && !out_ch.last)
        |=> (out_ch.out_stamp == $past(out_ch.out_stamp)))
        else $error("delete stamp differs from its insert");

endmodule

// ===== tb/count_sliding_window_expirer_unit_tb.sv =====
// ---------------------------------------------------------------------------
// count_sliding_window_expirer_unit_tb: self-checking bench of the window expirer
// Streams tuples and heartbeats through the block under random idling on
// both channels, programs the window size over the APB port between phases,
// and checks each result against its table row or an in-bench window model.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module count_sliding_window_expirer_unit_tb;

    import csw_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 8;
    localparam int NUM_PHASES = 7;

    // One result transaction as the sink sees it
    typedef struct packed {
        kind_t       kind;
        logic [31:0] handle;
        logic [31:0] stamp;
        logic        last;
    } result_t;

    typedef enum logic {
        ROW_ELEMENT,
        ROW_REGISTER
    } row_op_t;

    // One line of the directed table: either an element or a register write.
    // typed rows carry their results written out; others go to the model.
    typedef struct packed {
        row_op_t               op;
        logic                  hb;
        logic [31:0]           stamp;
        logic [31:0]           handle;
        logic [APB_ADDR_W-1:0] reg_addr;
        logic [APB_DATA_W-1:0] reg_data;
        logic                  typed;
        logic [1:0]            n_res;
        result_t               r0;
        result_t               r1;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    csw_in_if  in_ch ();
    csw_out_if out_ch ();

    count_sliding_window_expirer_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    // Window model: handle store, oldest slot, fill level, last emitted stamp
    // and the programmed window size.
    logic [31:0]        win_mem [WINDOW_DEPTH];
    logic [PTR_W-1:0]   head_ptr;
    logic [FILL_W-1:0]  occupancy;
    logic [31:0]        emitted_stamp;
    logic [WSIZE_W-1:0] size_reg;

    result_t     results_due [$];
    stim_row_t   dir_rows [$];
    result_t     want;
    int          bad_results;
    int          cycles_run;
    int          send_quiet;
    int          recv_quiet;
    logic [31:0] stream_stamp;

    logic [APB_DATA_W-1:0] phase_size  [NUM_PHASES];
    int                    phase_items [NUM_PHASES];
    bit                    phase_fill  [NUM_PHASES];
    int                    phase_tuple_pct [NUM_PHASES];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Pick an idle stretch: mostly none, some short, a few long, and now and
    // then a quiet run with no idling at all.
    function automatic int idle_len(inout int quiet);
        int r;
        if (quiet > 0)
        begin
            quiet--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            quiet = $urandom_range(20, 80);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Build an element row; n_res < 0 leaves the results to the model,
    // otherwise n_res results are written out, expired naming the delete.
    function automatic stim_row_t item_row(input logic hb, input logic [31:0] stamp,
                                           input logic [31:0] handle, input int n_res,
                                           input logic [31:0] expired);
        stim_row_t row;
        row        = '0;
        row.op     = ROW_ELEMENT;
        row.hb     = hb;
        row.stamp  = stamp;
        row.handle = handle;
        row.typed  = (n_res >= 0);
        row.n_res  = (n_res < 0) ? 2'd0 : 2'(n_res);
        if (hb)
            row.r0 = '{KIND_HEARTBEAT, 32'd0, stamp, 1'b1};
        else
        begin
            row.r0 = '{KIND_INSERT, handle, stamp, (n_res != 2)};
            row.r1 = '{KIND_DELETE, expired, stamp, 1'b1};
        end
        return row;
    endfunction

    function automatic stim_row_t reg_row(input logic [APB_ADDR_W-1:0] addr,
                                          input logic [APB_DATA_W-1:0] data);
        stim_row_t row;
        row          = '0;
        row.op       = ROW_REGISTER;
        row.reg_addr = addr;
        row.reg_data = data;
        return row;
    endfunction

    // Advance the window model by one accepted element and return the
    // results it causes, in order.
    task automatic window_advance(input logic hb, input logic [31:0] stamp,
                                  input logic [31:0] handle, output int n,
                                  output result_t r0, output result_t r1);
        int               eff;
        logic [PTR_W-1:0] wpos;
        logic [31:0]      expired;
        n  = 0;
        r0 = '0;
        r1 = '0;
        if (hb)
        begin
            // A heartbeat only speaks when it moves time past the last result
            if (emitted_stamp < stamp)
            begin
                emitted_stamp = stamp;
                r0 = '{KIND_HEARTBEAT, 32'd0, stamp, 1'b1};
                n  = 1;
            end
        end
        else
        begin
            // Zero acts as one, anything past the store depth as the depth
            if (size_reg == 0)
                eff = 1;
            else if (int'(size_reg) > WINDOW_DEPTH)
                eff = WINDOW_DEPTH;
            else
                eff = int'(size_reg);
            emitted_stamp = stamp;
            wpos = PTR_W'((int'(head_ptr) + int'(occupancy)) % WINDOW_DEPTH);
            if (int'(occupancy) >= eff)
            begin
                // Read the oldest slot before the write: with a full store
                // both land on the same slot.
                expired = win_mem[head_ptr];
                win_mem[wpos] = handle;
                head_ptr = PTR_W'((int'(head_ptr) + 1) % WINDOW_DEPTH);
                r0 = '{KIND_INSERT, handle, stamp, 1'b0};
                r1 = '{KIND_DELETE, expired, stamp, 1'b1};
                n  = 2;
            end
            else
            begin
                win_mem[wpos] = handle;
                occupancy = occupancy + FILL_W'(1);
                r0 = '{KIND_INSERT, handle, stamp, 1'b1};
                n  = 1;
            end
        end
    endtask

    // Offer one element, hold it until the block takes the transaction, then
    // queue the results it must cause.
    task automatic send_element(input stim_row_t row);
        int      gap;
        int      n_pred;
        result_t p0;
        result_t p1;
        gap = idle_len(send_quiet);
        @(negedge clk);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.is_heartbeat <= row.hb;
        in_ch.stamp        <= row.stamp;
        in_ch.tuple_handle <= row.handle;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        window_advance(row.hb, row.stamp, row.handle, n_pred, p0, p1);
        if (row.typed)
        begin
            if (row.n_res > 0)
                results_due.push_back(row.r0);
            if (row.n_res > 1)
                results_due.push_back(row.r1);
        end
        else
        begin
            if (n_pred > 0)
                results_due.push_back(p0);
            if (n_pred > 1)
                results_due.push_back(p1);
        end
    endtask

    // Drop valid, wait for every expected result, then let the pipeline
    // run dry so that a register write finds the block idle.
    task automatic settle_window();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle until pready
    task automatic reg_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        // Addresses past the register list are ignored by the block
        if ((int'(addr) >> 2) == CFG_WINDOW_SIZE)
            size_reg = WSIZE_W'(data);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Random element: stamps mostly hold or creep forward, with rare jumps
    // anywhere (which may run backward); handles mostly random.
    task automatic send_random(input int tuple_pct);
        int          r;
        logic        hb;
        logic [31:0] handle;
        hb = ($urandom_range(0, 99) >= tuple_pct);
        r = $urandom_range(0, 99);
        if (r < 40)
            stream_stamp = stream_stamp;
        else if (r < 80)
            stream_stamp = stream_stamp + $urandom_range(1, 4);
        else if (r < 94)
            stream_stamp = stream_stamp + $urandom_range(5, 100000);
        else
            stream_stamp = $urandom;
        r = $urandom_range(0, 99);
        if (r < 5)
            handle = 32'h0000_0000;
        else if (r < 10)
            handle = 32'hFFFF_FFFF;
        else
            handle = $urandom;
        send_element(item_row(hb, stream_stamp, handle, -1, 32'd0));
    endtask

    task automatic flag_field(input string name, input logic [31:0] exp_val,
                              input logic [31:0] got_val);
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, got_val);
        bad_results++;
    endtask

    // Result sink: stall at random, with stretches of steady ready
    initial
    begin
        int n;
        out_ch.ready = 1'b0;
        recv_quiet   = 0;
        forever
        begin
            n = idle_len(recv_quiet);
            if (n > 0)
            begin
                @(negedge clk);
                out_ch.ready <= 1'b0;
                repeat (n - 1) @(negedge clk);
            end
            @(negedge clk);
            out_ch.ready <= 1'b1;
        end
    end

    // Compare every result transaction with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            if (results_due.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual kind %0d handle %h stamp %h last %0b",
                         $time, out_ch.kind, out_ch.out_handle, out_ch.out_stamp, out_ch.last);
                bad_results++;
            end
            else
            begin
                want = results_due.pop_front();
                if (out_ch.kind !== want.kind)
                    flag_field("kind", 32'(want.kind), 32'(out_ch.kind));
                if (out_ch.out_handle !== want.handle)
                    flag_field("out_handle", want.handle, out_ch.out_handle);
                if (out_ch.out_stamp !== want.stamp)
                    flag_field("out_stamp", want.stamp, out_ch.out_stamp);
                if (out_ch.last !== want.last)
                    flag_field("last", 32'(want.last), 32'(out_ch.last));
            end
        end
    end

    // Watchdog: stop a hung run
    always @(posedge clk)
    begin
        cycles_run++;
        if (cycles_run > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, results_due.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        // Hold every input at a known value from time zero
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        in_ch.valid        = 1'b0;
        in_ch.is_heartbeat = 1'b0;
        in_ch.stamp        = '0;
        in_ch.tuple_handle = '0;
        bad_results        = 0;
        cycles_run         = 0;
        send_quiet         = 0;
        stream_stamp       = 32'd20;

        // Model state after reset; store entries are only read once written
        head_ptr      = '0;
        occupancy     = '0;
        emitted_stamp = '0;
        size_reg      = WSIZE_W'(1);

        // Directed table; the window size starts at its reset value of one
        dir_rows = '{
            // heartbeat at stamp zero right after reset: nothing is later
            item_row(1'b1, 32'd0, 32'hFFFF_FFFF, 0, 32'd0),
            item_row(1'b1, 32'd5, 32'd0, 1, 32'd0),
            // same stamp again: no second heartbeat
            item_row(1'b1, 32'd5, 32'd0, 0, 32'd0),
            item_row(1'b0, 32'd5, 32'hFFFF_FFFF, 1, 32'd0),
            // a tuple already carried this stamp out
            item_row(1'b1, 32'd5, 32'd0, 0, 32'd0),
            item_row(1'b0, 32'd7, 32'd0, 2, 32'hFFFF_FFFF),
            item_row(1'b0, 32'd7, 32'hA5A5_A5A5, 2, 32'd0),
            item_row(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'd0),
            item_row(1'b0, 32'hFFFF_FFFF, 32'h5A5A_5A5A, 2, 32'hA5A5_A5A5),
            item_row(1'b1, 32'hFFFF_FFFF, 32'd0, 0, 32'd0),
            // stamp runs backward: heartbeat stays silent, tuple still flows
            item_row(1'b1, 32'd3, 32'd0, 0, 32'd0),
            item_row(1'b0, 32'd3, 32'd1, 2, 32'h5A5A_5A5A),
            item_row(1'b1, 32'd4, 32'd0, 1, 32'd0),
            // window size zero behaves as one
            reg_row(APB_ADDR_W'(CFG_WINDOW_SIZE * 4), 32'd0),
            item_row(1'b0, 32'd9, 32'd2, 2, 32'd1),
            // write past the register list: no effect
            reg_row(APB_ADDR_W'(4), 32'd3),
            item_row(1'b0, 32'd9, 32'd3, 2, 32'd2),
            reg_row(APB_ADDR_W'(CFG_WINDOW_SIZE * 4), 32'd2),
            item_row(1'b0, 32'd10, 32'd4, -1, 32'd0),
            item_row(1'b0, 32'd10, 32'd5, -1, 32'd0),
            item_row(1'b1, 32'd11, 32'd0, -1, 32'd0),
            // largest field value saturates to the store depth
            reg_row(APB_ADDR_W'(CFG_WINDOW_SIZE * 4), 32'd2047),
            item_row(1'b0, 32'd12, 32'd6, -1, 32'd0),
            reg_row(APB_ADDR_W'(CFG_WINDOW_SIZE * 4), 32'(WINDOW_DEPTH)),
            item_row(1'b0, 32'd12, 32'd7, -1, 32'd0),
            // size dropped below the fill level: one expiry per tuple
            reg_row(APB_ADDR_W'(CFG_WINDOW_SIZE * 4), 32'd1),
            item_row(1'b0, 32'd13, 32'd8, -1, 32'd0),
            item_row(1'b0, 32'd13, 32'd9, -1, 32'd0)
        };

        // Random phases: garbage above the field, shrink below the fill,
        // small random size, zero, fill the whole store under saturation,
        // exact depth, then a tiny window over a full store.
        phase_size  = '{32'hABCD_0003, 32'd1, 32'd0, 32'd0, 32'd2047,
                        32'(WINDOW_DEPTH), 32'd2};
        phase_items = '{30, 25, 30, 20, 30, 20, 30};
        phase_fill  = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
        phase_tuple_pct = '{70, 70, 70, 70, 92, 75, 70};
        phase_size[2] = $urandom_range(4, 16);

        // Hold reset, then release it away from the clock edge
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Walk the directed table
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].op == ROW_REGISTER)
            begin
                settle_window();
                reg_write(dir_rows[i].reg_addr, dir_rows[i].reg_data);
            end
            else
                send_element(dir_rows[i]);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            settle_window();
            reg_write(APB_ADDR_W'(CFG_WINDOW_SIZE * 4), phase_size[p]);
            // Fill phases keep pushing until the whole store is occupied
            if (phase_fill[p])
            begin
                while (int'(occupancy) < WINDOW_DEPTH)
                    send_random(phase_tuple_pct[p]);
            end
            repeat (phase_items[p]) send_random(phase_tuple_pct[p]);
        end

        // Drain, give stray results time to show up, then report
        settle_window();
        if (bad_results == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
src/csw_pkg.sv
src/csw_in_if.sv
src/csw_out_if.sv
src/csw_window_ram.sv
src/csw_ctrl.sv
src/csw_emit.sv
src/count_sliding_window_expirer_unit.sv
tb/count_sliding_window_expirer_unit_tb.sv
